@@ hdl/calibration_table_distance_interp_defines.svh @@
// Assertion macros shared by the calibration interpolation block.
`ifndef CALIBRATION_TABLE_DISTANCE_INTERP_DEFINES_SVH
`define CALIBRATION_TABLE_DISTANCE_INTERP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTDI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calibration interpolation check failed");

// The consequent must hold in the cycle after the antecedent.
`define CTDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calibration interpolation sequencing check failed");

`endif

@@ hdl/ctdi_pkg.sv @@
package ctdi_pkg;

    localparam int SENSORS  = 32;
    localparam int POINTS   = 32;

    localparam int SENSOR_W = 5;
    localparam int POINT_W  = 5;
    localparam int CODE_W   = 12;
    localparam int DIST_W   = 8;

    localparam int ADDR_W   = $clog2(SENSORS * POINTS);
    localparam int IDX_W    = (POINTS > 2) ? $clog2(POINTS) : 1;
    localparam int ALU_W    = 16;

    localparam int STEP_MM  = 10;
    localparam int MAX_MM   = 199;

    // The interpolation quotient never exceeds STEP_MM, so four bits suffice.
    localparam int QUO_W    = 4;
    localparam int STEP_W   = $clog2(QUO_W);

    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CODE_W-1:0] t_code;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } t_alu_rsp;

endpackage

@@ hdl/ctdi_alu.sv @@
module ctdi_alu
    import ctdi_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W:0] w_sum;

    always_comb begin
        unique case (i_req.op)
            ALU_ADD: w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
            default: w_sum = '0;
        endcase
    end

    // For a subtraction the top bit is the borrow, so it flags a < b.
    assign o_rsp.res    = w_sum[ALU_W-1:0];
    assign o_rsp.borrow = w_sum[ALU_W];

endmodule

@@ hdl/ctdi_table.sv @@
module ctdi_table
    import ctdi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_we,
    input  t_addr i_waddr,
    input  t_code i_wdata,
    input  t_addr i_raddr,
    output t_code o_rdata
);

    t_code r_mem [SENSORS*POINTS];
    t_code r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/calibration_table_distance_interp.sv @@
// Piecewise-linear calibration of raw profile sensor codes to millimetres. Each sensor
// owns a descending row of calibration codes, one per 10 mm, held in a single-port-write,
// registered-read table. A write transaction (func 0) stores one code, gives no result and
// leaves the block idle. A convert transaction (func 1) scans the sensor's row one
// point per cycle through the table read port, then interpolates using one shared
// 16-bit add/subtract unit: two differences, a times-ten step, a four-step restoring
// divide and a final add. A convert that stops at point k with k below 2 gives zero
// without interpolating, one that stops at a later point interpolates there, and one whose
// sample lies below the whole row saturates and is flagged off the table; the result then
// waits for a free output register. The next transaction is accepted in the cycle after
// that load, even while the previous result is still waiting in the output register.
// Table contents are undefined after reset; only written entries may be read.
module calibration_table_distance_interp
    import ctdi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_func,
    input  logic [SENSOR_W-1:0] i_sensor,
    input  logic [POINT_W-1:0]  i_point,
    input  logic [CODE_W-1:0]   i_entry_value,
    input  logic [CODE_W-1:0]   i_sample,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [DIST_W-1:0]   o_distance_mm,
    output logic                o_off_table
);

`include "calibration_table_distance_interp_defines.svh"

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DIFF1 = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIFF2 = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_SUM   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [IDX_W-1:0]  r_idx;
    t_addr             r_base;
    t_code             r_sample;
    t_code             r_prev;
    t_code             r_cur;
    t_code             r_div;
    logic [ALU_W-1:0]  r_num;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic [DIST_W-1:0] r_dist;
    logic              r_off;
    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_off;

    logic     w_in_acc;
    logic     w_out_acc;
    logic     w_load;
    logic     w_sensor_ok;
    logic     w_point_ok;
    logic     w_found;
    logic     w_last;
    t_addr    w_in_base;
    t_addr    w_raddr;
    t_code    w_rdata;
    t_alu_req w_req;
    t_alu_rsp w_rsp;

    assign o_stall   = (r_state != S_IDLE);
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_out_valid && !i_stall;
    // A finished result moves to the output register once that register is free.
    assign w_load    = (r_state == S_FIN) && (!r_out_valid || !i_stall);

    assign w_sensor_ok = (32'(i_sensor) < SENSORS);
    assign w_point_ok  = (32'(i_point) < POINTS);
    assign w_in_base   = ADDR_W'(32'(i_sensor) * POINTS);

    // In idle the read starts at point 0 of the requested row so that the first
    // scan cycle already sees its data; while scanning, the next point is fetched.
    always_comb begin
        if (r_state == S_IDLE) begin
            w_raddr = w_in_base;
        end else begin
            w_raddr = r_base + ADDR_W'(r_idx) + ADDR_W'(1);
        end
    end

    ctdi_table u_table (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && (i_func == FUNC_WRITE) && w_sensor_ok && w_point_ok),
        .i_waddr (w_in_base + ADDR_W'(i_point)),
        .i_wdata (i_entry_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Operand selection for the shared add/subtract unit.
    always_comb begin
        w_req.op = ALU_SUB;
        w_req.a  = ALU_W'(r_sample);
        w_req.b  = ALU_W'(w_rdata);
        unique case (r_state)
            S_DIFF1: begin
                w_req.a = ALU_W'(r_prev);
                w_req.b = ALU_W'(r_sample);
            end
            S_MUL: begin
                // Times ten as eight times plus two times.
                w_req.op = ALU_ADD;
                w_req.a  = r_num << 3;
                w_req.b  = r_num << 1;
            end
            S_DIFF2: begin
                w_req.a = ALU_W'(r_prev);
                w_req.b = ALU_W'(r_cur);
            end
            S_DIV: begin
                w_req.a = r_num;
                w_req.b = ALU_W'(r_div) << r_step;
            end
            S_SUM: begin
                w_req.op = ALU_ADD;
                w_req.a  = ALU_W'(r_idx) * ALU_W'(STEP_MM);
                w_req.b  = ALU_W'(r_quo);
            end
            default: begin
                w_req.op = ALU_SUB;
            end
        endcase
    end

    ctdi_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // While scanning, no borrow on sample minus entry means the entry is not above
    // the sample, which ends the search.
    assign w_found = !w_rsp.borrow;
    assign w_last  = (r_idx == IDX_W'(POINTS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_func == FUNC_CONVERT)) begin
                    n_state = w_sensor_ok ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (w_found) begin
                    n_state = (r_idx <= IDX_W'(1)) ? S_FIN : S_DIFF1;
                end else if (w_last) begin
                    n_state = S_FIN;
                end
            end
            S_DIFF1: n_state = S_MUL;
            S_MUL:   n_state = S_DIFF2;
            S_DIFF2: n_state = S_DIV;
            S_DIV: begin
                if (r_step == '0) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: n_state = S_FIN;
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_idx    <= '0;
                r_base   <= w_in_base;
                r_sample <= i_sample;
                r_dist   <= '0;
                r_off    <= 1'b0;
            end
            S_SCAN: begin
                if (w_found) begin
                    r_cur <= w_rdata;
                end else if (w_last) begin
                    r_dist <= DIST_W'(MAX_MM);
                    r_off  <= 1'b1;
                end else begin
                    r_prev <= w_rdata;
                    r_idx  <= r_idx + IDX_W'(1);
                end
            end
            S_DIFF1: r_num <= w_rsp.res;
            S_MUL:   r_num <= w_rsp.res;
            S_DIFF2: begin
                r_div  <= w_rsp.res[CODE_W-1:0];
                r_step <= STEP_W'(QUO_W - 1);
                r_quo  <= '0;
            end
            S_DIV: begin
                // Restoring division: keep the difference only when it did not borrow.
                if (!w_rsp.borrow) begin
                    r_num <= w_rsp.res;
                end
                r_quo  <= {r_quo[QUO_W-2:0], !w_rsp.borrow};
                r_step <= r_step - STEP_W'(1);
            end
            S_SUM: begin
                if (w_rsp.res > ALU_W'(MAX_MM)) begin
                    r_dist <= DIST_W'(MAX_MM);
                end else begin
                    r_dist <= w_rsp.res[DIST_W-1:0];
                end
            end
            S_FIN: begin
                if (w_load) begin
                    r_out_dist <= r_dist;
                    r_out_off  <= r_off;
                end
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_distance_mm = r_out_dist;
    assign o_off_table   = r_out_off;

    // A saturated result always carries the largest distance.
    `CTDI_ASSERT_NOW(a_off_saturates, i_clk, i_rst_n, o_valid && o_off_table, o_distance_mm == DIST_W'(MAX_MM))
    // Every delivered distance lies within the clamp range.
    `CTDI_ASSERT_NOW(a_dist_range, i_clk, i_rst_n, o_valid, o_distance_mm <= DIST_W'(MAX_MM))
    // The divisor is positive whenever the divide runs.
    `CTDI_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_div != '0)
    // A table write returns to idle without entering the conversion sequence.
    `CTDI_ASSERT_NEXT(a_write_idle, i_clk, i_rst_n, w_in_acc && (i_func == FUNC_WRITE), r_state == S_IDLE)

endmodule

@@ sim/tb_calibration_table_distance_interp.sv @@
`timescale 1ns / 1ps

module tb_calibration_table_distance_interp;
    import ctdi_pkg::*;

    // Limit on the stretch with no transaction on either side before the watchdog ends the run.
    // It lies well beyond the longest convert, the sender gaps and the receiver stall runs.
    localparam int IDLE_LIMIT   = 2000;
    localparam int TARGET_ITEMS = 1250;
    localparam int TAIL_CYCLES  = 60;
    localparam int MAX_REPORTS  = 40;

    typedef struct {
        logic                func;
        logic [SENSOR_W-1:0] sensor;
        logic [POINT_W-1:0]  point;
        logic [CODE_W-1:0]   entry_value;
        logic [CODE_W-1:0]   sample;
        bit                  drain;     // hold this one back until all results are in
    } t_cal_item;

    typedef struct {
        logic [DIST_W-1:0] distance_mm;
        logic              off_table;
    } t_distance;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic                i_func        = FUNC_WRITE;
    logic [SENSOR_W-1:0] i_sensor      = '0;
    logic [POINT_W-1:0]  i_point       = '0;
    logic [CODE_W-1:0]   i_entry_value = '0;
    logic [CODE_W-1:0]   i_sample      = '0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic [DIST_W-1:0]   o_distance_mm;
    logic                o_off_table;

    calibration_table_distance_interp dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_sensor      (i_sensor),
        .i_point       (i_point),
        .i_entry_value (i_entry_value),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_distance_mm (o_distance_mm),
        .o_off_table   (o_off_table)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Transactions waiting to be driven, and the distances still owed by the block.
    t_cal_item pending_items[$];
    t_distance expected_distances[$];

    // Calibration rows as the block holds them, updated when a write is accepted.
    t_code cal_table [SENSORS][POINTS];

    // Calibration rows as planned by the stimulus, used to pick convert samples and to keep
    // every convert away from entries that were never written.
    t_code plan_table   [SENSORS][POINTS];
    bit    plan_written [SENSORS][POINTS];
    bit    drain_next;

    int mismatches;
    int idle_cycles;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Scan the row from point 0 for the first code not above the sample, then
    // interpolate between it and the code before it in 10 mm steps.
    function automatic t_distance interp_distance(input logic [SENSOR_W-1:0] sensor,
                                                  input logic [CODE_W-1:0] sample);
        t_distance   res;
        int unsigned idx;
        int unsigned prev_code;
        int unsigned cur_code;
        int unsigned dist_mm;
        res.distance_mm = '0;
        res.off_table   = 1'b0;
        idx             = 0;
        if (sensor >= SENSORS) begin
            return res;
        end
        while (idx < POINTS && sample < cal_table[sensor][idx]) begin
            idx++;
        end
        if (idx >= POINTS) begin
            // The sample sits below the whole row: saturate and flag it.
            res.distance_mm = DIST_W'(MAX_MM);
            res.off_table   = 1'b1;
        end else if (idx >= 2) begin
            prev_code = cal_table[sensor][idx-1];
            cur_code  = cal_table[sensor][idx];
            dist_mm = STEP_MM * idx + (STEP_MM * (prev_code - sample)) / (prev_code - cur_code);
            if (dist_mm > MAX_MM) begin
                dist_mm = MAX_MM;
            end
            res.distance_mm = DIST_W'(dist_mm);
        end
        return res;
    endfunction

    // Apply one accepted transaction: a write updates the table, a convert owes a result.
    function automatic void accept_transaction(input t_cal_item item);
        if (item.func == FUNC_WRITE) begin
            if (item.sensor < SENSORS && item.point < POINTS) begin
                cal_table[item.sensor][item.point] = item.entry_value;
            end
        end else begin
            expected_distances.push_back(interp_distance(item.sensor, item.sample));
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------

    // True when a scan for this sample only touches entries that were written.
    function automatic bit plan_scan_ok(input int sensor, input int sample);
        for (int p = 0; p < POINTS; p++) begin
            if (!plan_written[sensor][p]) begin
                return 1'b0;
            end
            if (sample >= plan_table[sensor][p]) begin
                return 1'b1;
            end
        end
        return 1'b1;
    endfunction

    // The sample field means nothing on a write, so it carries random bits.
    task automatic queue_write(input int sensor, input int point, input int code);
        t_cal_item item;
        item.func        = FUNC_WRITE;
        item.sensor      = SENSOR_W'(sensor);
        item.point       = POINT_W'(point);
        item.entry_value = CODE_W'(code);
        item.sample      = CODE_W'($urandom);
        item.drain       = drain_next;
        drain_next       = 1'b0;
        pending_items.push_back(item);
        plan_table[sensor][point]   = CODE_W'(code);
        plan_written[sensor][point] = 1'b1;
    endtask

    // A convert that would read an unwritten entry is turned into a top-of-row
    // sample, which stops at point 0; a row with no point 0 gets no convert at all.
    // Point and entry value are ignored on a convert and carry random bits.
    task automatic queue_convert(input int sensor, input int sample);
        t_cal_item item;
        if (!plan_written[sensor][0]) begin
            return;
        end
        if (!plan_scan_ok(sensor, sample)) begin
            sample = (1 << CODE_W) - 1;
        end
        item.func        = FUNC_CONVERT;
        item.sensor      = SENSOR_W'(sensor);
        item.point       = POINT_W'($urandom);
        item.entry_value = CODE_W'($urandom);
        item.sample      = CODE_W'(sample);
        item.drain       = drain_next;
        drain_next       = 1'b0;
        pending_items.push_back(item);
    endtask

    initial begin
        int sensor;
        int top_code;
        int step_max;
        int seq_kind;
        int seq_count;
        int n_conv;
        int kind_ofs;
        int sample;
        int row_codes [POINTS];

        drain_next = 1'b0;
        seq_count  = 0;

        // Directed part. Sensor 0 gets a short descending row that runs down to
        // code 0; the converts hit the top of the row, the second point (which must
        // give zero), exact entry matches and the interpolated middle.
        queue_write(0, 0, 4095);
        queue_write(0, 1, 3000);
        queue_write(0, 2, 1000);
        queue_write(0, 3, 0);
        queue_convert(0, 4095);
        queue_convert(0, 3500);
        queue_convert(0, 3000);
        queue_convert(0, 2000);
        queue_convert(0, 1000);
        queue_convert(0, 999);
        queue_convert(0, 0);
        // The last sensor and the last point; a zero code at point 0 stops any scan.
        queue_write(31, 31, 4095);
        queue_write(31, 0, 0);
        queue_convert(31, 0);
        queue_convert(31, 4095);
        // Overwrite an entry and make sure the new code takes effect.
        queue_write(0, 1, 2500);
        queue_convert(0, 2600);
        queue_convert(0, 2500);
        queue_convert(0, 1750);

        // Random part, built from sequences. Most are full row fills followed by a
        // run of converts on that row; the rest are loose converts and stray writes
        // that break the descending order of rows.
        drain_next = 1'b1;
        while (pending_items.size() < TARGET_ITEMS) begin
            seq_count++;
            if (seq_count % 8 == 0) begin
                drain_next = 1'b1;
            end
            seq_kind = $urandom_range(0, 9);
            sensor   = $urandom_range(0, SENSORS - 1);
            if (seq_kind < 6) begin
                // A descending row whose last code stays above zero, so that a
                // sample below the whole row always exists. Zero steps give equal
                // neighbours.
                top_code = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(2000, 4095);
                step_max = top_code / 40;
                row_codes[0] = top_code;
                for (int p = 1; p < POINTS; p++) begin
                    row_codes[p] = row_codes[p-1] - $urandom_range(0, step_max);
                end
                if ($urandom_range(0, 1) == 1) begin
                    for (int p = 0; p < POINTS; p++) begin
                        queue_write(sensor, p, row_codes[p]);
                    end
                end else begin
                    for (int p = POINTS - 1; p >= 0; p--) begin
                        queue_write(sensor, p, row_codes[p]);
                    end
                end
                // Every run of converts covers each kind of sample at least once.
                n_conv   = $urandom_range(6, 20);
                kind_ofs = $urandom_range(0, 5);
                for (int j = 0; j < n_conv; j++) begin
                    case ((j + kind_ofs) % 6)
                        0: sample = plan_table[sensor][POINTS-1] - 1;
                        1: sample = plan_table[sensor][$urandom_range(0, POINTS - 1)];
                        2: sample = $urandom_range(plan_table[sensor][POINTS-1],
                                                   plan_table[sensor][20]);
                        3: sample = 4095;
                        default: sample = $urandom_range(plan_table[sensor][POINTS-1],
                                                         plan_table[sensor][0]);
                    endcase
                    queue_convert(sensor, sample);
                end
            end else if (seq_kind < 8) begin
                n_conv = $urandom_range(3, 10);
                for (int j = 0; j < n_conv; j++) begin
                    queue_convert($urandom_range(0, SENSORS - 1), $urandom_range(0, 4095));
                end
            end else begin
                n_conv = $urandom_range(1, 6);
                for (int j = 0; j < n_conv; j++) begin
                    queue_write($urandom_range(0, SENSORS - 1), $urandom_range(0, POINTS - 1),
                                $urandom_range(0, 4095));
                end
            end
        end

        // Reset is held low at the start and released once.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every transaction is accepted and every result has come back,
        // then give the block a little longer to show any stray result.
        while (pending_items.size() != 0 || i_valid || expected_distances.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. A transaction
    // marked for draining waits until nothing is owed by the block.
    // ------------------------------------------------------------------
    t_cal_item cur_item;
    int        burst_left;
    int        gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_valid && !o_stall) begin
                accept_transaction(cur_item);
            end
            // A stalled transaction stays on the bus untouched.
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() != 0 &&
                             (!pending_items[0].drain || expected_distances.size() == 0)) begin
                    cur_item = pending_items.pop_front();
                    i_valid       <= 1'b1;
                    i_func        <= cur_item.func;
                    i_sensor      <= cur_item.sensor;
                    i_point       <= cur_item.point;
                    i_entry_value <= cur_item.entry_value;
                    i_sample      <= cur_item.sample;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: solid stall runs, long open stretches, and short
    // choppy phases, chosen independently of the result valid.
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        if (stall_left <= 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    i_stall    <= 1'b1;
                    stall_left = $urandom_range(1, 12);
                end
                1: begin
                    i_stall    <= 1'b0;
                    stall_left = $urandom_range(20, 80);
                end
                default: begin
                    i_stall    <= 1'($urandom_range(0, 1));
                    stall_left = $urandom_range(0, 3);
                end
            endcase
        end else begin
            stall_left--;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each accepted result is checked against the oldest owed distance.
    // ------------------------------------------------------------------
    t_distance want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_distances.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected result, expected none, actual distance %0d off_table %0b",
                             $time, o_distance_mm, o_off_table);
                end
            end else begin
                want = expected_distances.pop_front();
                if (o_distance_mm !== want.distance_mm) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: distance_mm mismatch, expected %0d actual %0d",
                                 $time, want.distance_mm, o_distance_mm);
                    end
                end
                if (o_off_table !== want.off_table) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: off_table mismatch, expected %0b actual %0b",
                                 $time, want.off_table, o_off_table);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when neither side has moved for too long.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results still owed",
                     $time, IDLE_LIMIT, expected_distances.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ctdi_pkg.sv
hdl/ctdi_alu.sv
hdl/ctdi_table.sv
hdl/calibration_table_distance_interp.sv
sim/tb_calibration_table_distance_interp.sv
